>>> rtl/core/tipd_pkg.sv
// Shared types and constants for the timed input pattern detector.
// Used by tipd_step and timed_input_pattern_detector; no dependencies.

package tipd_pkg;

    localparam int PHASE_LIMIT    = 4;
    localparam int LEVEL_LIMIT    = 8;
    localparam int DURATION_BITS  = 16;
    localparam int PHASE_BITS     = 2;
    localparam int STEP_BITS      = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_DURATIONS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIXED_MASK      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STATE_COUNTS    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STATE_LEVELS    = 3'd4;

    // item opcodes
    localparam logic [1:0] OP_ACTIVITY = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_CHECK    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PROGRESS = 2'd1,
        ST_COMPLETE = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  phase_count;
        logic [63:0] phase_durations;
        logic [3:0]  fixed_mask;
        logic [15:0] state_counts;
        logic [31:0] state_levels;
    } tipd_cfg_t;

    typedef struct packed {
        logic                     started;
        logic [PHASE_BITS-1:0]    phase;
        status_t                  status;
        logic [STEP_BITS-1:0]     step;
        logic [DURATION_BITS-1:0] timer;
        logic                     running;
        logic                     done;
    } tipd_state_t;

    localparam tipd_state_t STATE_CLEAR = '{
        started: 1'b0,
        phase:   '0,
        status:  ST_IDLE,
        step:    '0,
        timer:   '0,
        running: 1'b0,
        done:    1'b0
    };

endpackage

>>> rtl/core/tipd_step.sv
// Next-state logic for one item of the pattern detector.
// Depends on tipd_pkg (state and configuration structs, opcodes).

module tipd_step (
    input  tipd_pkg::tipd_cfg_t   cfg,
    input  tipd_pkg::tipd_state_t state_cur,
    input  logic [1:0]            opcode,
    input  logic                  level,
    output tipd_pkg::tipd_state_t state_nxt,
    output logic                  detected
);

    function automatic logic [2:0] eff_count(tipd_pkg::tipd_cfg_t c);
        return (c.phase_count > 3'(tipd_pkg::PHASE_LIMIT)) ?
               3'(tipd_pkg::PHASE_LIMIT) : c.phase_count;
    endfunction

    function automatic logic [3:0] level_count(tipd_pkg::tipd_cfg_t c, logic [1:0] p);
        logic [3:0] nib;
        nib = c.state_counts[{p, 2'b00} +: 4];
        return (nib > 4'(tipd_pkg::LEVEL_LIMIT)) ? 4'(tipd_pkg::LEVEL_LIMIT) : nib;
    endfunction

    function automatic logic [tipd_pkg::DURATION_BITS-1:0] duration_of(
        tipd_pkg::tipd_cfg_t c, logic [1:0] p);
        return c.phase_durations[{p, 4'b0000} +: tipd_pkg::DURATION_BITS];
    endfunction

    // timer expiry: advance, finish or drop the pattern
    function automatic tipd_pkg::tipd_state_t expire(tipd_pkg::tipd_state_t s,
                                                     tipd_pkg::tipd_cfg_t c);
        tipd_pkg::tipd_state_t r;
        logic [2:0] cnt;
        logic [3:0] n;
        logic [2:0] nxt;
        r   = s;
        cnt = eff_count(c);
        n   = level_count(c, s.phase);
        nxt = {1'b0, s.phase} + 3'd1;
        if (cnt == 3'd0)
        begin
            r = tipd_pkg::STATE_CLEAR;
        end
        else if (s.status == tipd_pkg::ST_COMPLETE || n == 4'd0)
        begin
            if (n == 4'd0 && s.status != tipd_pkg::ST_IDLE)
            begin
                r = tipd_pkg::STATE_CLEAR;
            end
            else if (nxt >= cnt)
            begin
                r.done = 1'b1;
            end
            else
            begin
                r.phase   = nxt[1:0];
                r.status  = tipd_pkg::ST_IDLE;
                r.step    = '0;
                r.timer   = duration_of(c, nxt[1:0]);
                r.running = 1'b1;
            end
        end
        else
        begin
            r = tipd_pkg::STATE_CLEAR;
        end
        return r;
    endfunction

    always_comb
    begin
        tipd_pkg::tipd_state_t s;
        logic [3:0] n;
        s        = state_cur;
        detected = 1'b0;
        n        = '0;
        case (opcode)
            tipd_pkg::OP_ACTIVITY:
            begin
                if (eff_count(cfg) != 3'd0)
                begin
                    if (!s.started)
                    begin
                        s.started = 1'b1;
                        s.phase   = '0;
                    end
                    n = level_count(cfg, s.phase);
                    if (s.status == tipd_pkg::ST_IDLE)
                    begin
                        s.step   = '0;
                        s.status = tipd_pkg::ST_PROGRESS;
                        if (s.phase == 2'd0)
                        begin
                            s.timer   = duration_of(cfg, 2'd0);
                            s.running = 1'b1;
                        end
                    end
                    if (s.status == tipd_pkg::ST_PROGRESS)
                    begin
                        if (n != 4'd0 && cfg.state_levels[{s.phase, s.step[2:0]}] == level)
                            s.step = s.step + 4'd1;
                        if (s.step >= n)
                        begin
                            s.status = tipd_pkg::ST_COMPLETE;
                            if (!cfg.fixed_mask[s.phase])
                            begin
                                s.running = 1'b0;
                                s.timer   = '0;
                                s = expire(s, cfg);
                            end
                        end
                    end
                    else if (s.status == tipd_pkg::ST_COMPLETE)
                    begin
                        s = tipd_pkg::STATE_CLEAR;
                    end
                end
            end
            tipd_pkg::OP_TICK:
            begin
                if (s.running)
                begin
                    if (s.timer <= 16'd1)
                    begin
                        s.running = 1'b0;
                        s.timer   = '0;
                        s = expire(s, cfg);
                    end
                    else
                    begin
                        s.timer = s.timer - 16'd1;
                    end
                end
            end
            tipd_pkg::OP_CHECK:
            begin
                if (s.done)
                begin
                    detected = 1'b1;
                    s = tipd_pkg::STATE_CLEAR;
                end
            end
            default:
            begin
            end
        endcase
        state_nxt = s;
    end

endmodule

>>> rtl/core/timed_input_pattern_detector.sv
// Top level of the timed input pattern detector: config registers, state
// registers and result register. Depends on tipd_pkg and tipd_step.
//
// Usage:
//   Slave stream (s_*): one transaction per item. s_tuser carries the
//   opcode (activity, tick, check); s_tdata[0] carries the pin level.
//   Master stream (m_*): one result per item, registered on acceptance.
//   Config port: cfg_we writes cfg_wdata into register cfg_index on the
//   clock edge; indexes beyond the register list are dropped. Write only
//   while no item is in flight.
// Throughput: one item per cycle while results are taken; the update is a
//   single pass of next-state logic between the state and result registers.
// Latency: the result is valid the cycle after the item is accepted.
// Stall: with m_tvalid high and m_tready low the result holds and s_tready
//   drops; s_tready follows m_tready in the same cycle, so a result taken
//   while a new item arrives costs no bubble.
// Reset: rst_n clears the config registers, the pattern state and m_tvalid.

module timed_input_pattern_detector (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [0] input_level
    input  logic [1:0]                           s_tuser,   // [1:0] opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] detected, [1] complete_flag, [2] started_flag, [4:3] active_phase,
    // [6:5] active_status, [10:7] matched_steps
    output logic [15:0]                          m_tdata,
    input  logic                                 cfg_we,
    input  logic [tipd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tipd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    tipd_pkg::tipd_cfg_t   cfg_reg;
    tipd_pkg::tipd_state_t state_reg;
    tipd_pkg::tipd_state_t state_next;
    logic                  detected;
    logic                  m_tvalid_reg;
    logic [15:0]           m_tdata_reg;
    logic                  s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tipd_pkg::REG_PHASE_COUNT:     cfg_reg.phase_count     <= cfg_wdata[2:0];
                tipd_pkg::REG_PHASE_DURATIONS: cfg_reg.phase_durations <= cfg_wdata;
                tipd_pkg::REG_FIXED_MASK:      cfg_reg.fixed_mask      <= cfg_wdata[3:0];
                tipd_pkg::REG_STATE_COUNTS:    cfg_reg.state_counts    <= cfg_wdata[15:0];
                tipd_pkg::REG_STATE_LEVELS:    cfg_reg.state_levels    <= cfg_wdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    tipd_step u_step (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .opcode    (s_tuser),
        .level     (s_tdata[0]),
        .state_nxt (state_next),
        .detected  (detected)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tipd_pkg::STATE_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                state_reg <= state_next;
            if (s_accept)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            m_tdata_reg <= {5'b00000, state_next.step, state_next.status, state_next.phase,
                            state_next.started, state_next.done, detected};
    end

`ifndef SYNTH
    a_done_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.done |-> state_reg.started)
        else $error("pattern done without a started pattern");

    a_complete_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status == tipd_pkg::ST_COMPLETE) |-> state_reg.started)
        else $error("phase complete without a started pattern");

    a_timer_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.running |-> (state_reg.timer == '0))
        else $error("stopped timer holds a count");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step <= 4'(tipd_pkg::LEVEL_LIMIT))
        else $error("matched steps beyond level limit");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (m_tvalid && m_tdata[2] == state_reg.started
                      && m_tdata[1] == state_reg.done))
        else $error("result flags disagree with state");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for timed_input_pattern_detector.
// Drives item streams and config writes, predicts each result in a local model
// of the detector and compares every output transaction. Depends on tipd_pkg.
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 200;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] op;
        logic       lvl;
    } pin_item_t;

    // same order as m_tdata, detected in the lowest bit
    typedef struct packed {
        logic [3:0] steps;
        logic [1:0] status;
        logic [1:0] phase;
        logic       started;
        logic       complete;
        logic       detected;
    } pattern_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [63:0] cfg_wdata = 64'd0;

    timed_input_pattern_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the config registers
    logic [2:0]  cfg_phases = '0;
    logic [63:0] cfg_durs   = '0;
    logic [3:0]  cfg_fixed  = '0;
    logic [15:0] cfg_counts = '0;
    logic [31:0] cfg_levels = '0;

    // predictor copy of the pattern state
    logic              pat_started = 1'b0;
    logic [1:0]        cur_phase   = '0;
    tipd_pkg::status_t cur_status  = tipd_pkg::ST_IDLE;
    logic [3:0]        cur_step    = '0;
    logic [15:0]       tmr_left    = '0;
    logic              tmr_on      = 1'b0;
    logic              pat_done    = 1'b0;

    pin_item_t       pending_items[$];
    pattern_result_t expected_results[$];
    int              queued_count = 0;
    int              fail_count = 0;
    int              idle_mode = 0;     // 0 none, 1 sender, 2 receiver, 3 both
    logic            in_accepted = 1'b0;
    logic            hold_on = 1'b0;
    event            hold_kick;

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic int unsigned phases_used();
        return (cfg_phases > 3'd4) ? 4 : int'(cfg_phases);
    endfunction

    function automatic int unsigned levels_of(int unsigned p);
        int unsigned n;
        n = 32'(cfg_counts[p*4 +: 4]);
        return (n > 8) ? 8 : n;
    endfunction

    function automatic void clear_pattern();
        pat_started = 1'b0;
        cur_phase   = '0;
        cur_status  = tipd_pkg::ST_IDLE;
        cur_step    = '0;
        tmr_left    = '0;
        tmr_on      = 1'b0;
        pat_done    = 1'b0;
    endfunction

    function automatic void on_expiry();
        int unsigned cnt;
        int unsigned p;
        int unsigned n;
        cnt = phases_used();
        p = 32'(cur_phase);
        n = levels_of(p);
        if (cnt == 0)
            clear_pattern();
        else if (cur_status == tipd_pkg::ST_COMPLETE || n == 0)
        begin
            if (n == 0 && cur_status != tipd_pkg::ST_IDLE)
                clear_pattern();
            else if (p + 1 >= cnt)
                pat_done = 1'b1;
            else
            begin
                cur_phase  = 2'(p + 1);
                cur_status = tipd_pkg::ST_IDLE;
                cur_step   = '0;
                tmr_left   = cfg_durs[(p+1)*16 +: 16];
                tmr_on     = 1'b1;
            end
        end
        else
            clear_pattern();
    endfunction

    function automatic void on_activity(logic lvl);
        int unsigned p;
        int unsigned n;
        int unsigned k;
        if (phases_used() == 0)
            return;
        if (!pat_started)
        begin
            pat_started = 1'b1;
            cur_phase   = '0;
        end
        p = 32'(cur_phase);
        n = levels_of(p);
        if (cur_status == tipd_pkg::ST_IDLE)
        begin
            cur_step   = '0;
            cur_status = tipd_pkg::ST_PROGRESS;
            if (p == 0)
            begin
                tmr_left = cfg_durs[15:0];
                tmr_on   = 1'b1;
            end
        end
        if (cur_status == tipd_pkg::ST_PROGRESS)
        begin
            if (n > 0)
            begin
                k = 32'(cur_step[2:0]) + p * 8;
                if (cfg_levels[k] == lvl)
                    cur_step = cur_step + 4'd1;
            end
            if (32'(cur_step) >= n)
            begin
                cur_status = tipd_pkg::ST_COMPLETE;
                if (!cfg_fixed[p])
                begin
                    tmr_on   = 1'b0;
                    tmr_left = '0;
                    on_expiry();
                end
            end
        end
        else if (cur_status == tipd_pkg::ST_COMPLETE)
            clear_pattern();
    endfunction

    function automatic pattern_result_t detector_step(logic [1:0] op, logic lvl);
        pattern_result_t r;
        r.detected = 1'b0;
        case (op)
            tipd_pkg::OP_ACTIVITY: on_activity(lvl);
            tipd_pkg::OP_TICK:
                if (tmr_on)
                begin
                    if (tmr_left <= 16'd1)
                    begin
                        tmr_on   = 1'b0;
                        tmr_left = '0;
                        on_expiry();
                    end
                    else
                        tmr_left = tmr_left - 16'd1;
                end
            tipd_pkg::OP_CHECK:
                if (pat_done)
                begin
                    r.detected = 1'b1;
                    clear_pattern();
                end
            default: ;
        endcase
        r.complete = pat_done;
        r.started  = pat_started;
        r.phase    = cur_phase;
        r.status   = cur_status;
        r.steps    = cur_step;
        return r;
    endfunction

    // ---------------- driver ----------------
    always @(negedge clk)
    begin : item_driver
        pin_item_t it;
        if (!s_tvalid || in_accepted)
        begin
            if (pending_items.size() != 0 &&
                !((idle_mode == 1 && $urandom_range(99, 0) < 63) ||
                  (idle_mode == 3 && $urandom_range(99, 0) < 33)))
            begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.op;
                s_tdata  <= {7'd0, it.lvl};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= !hold_on &&
                    !((idle_mode == 2 && $urandom_range(99, 0) < 63) ||
                      (idle_mode == 3 && $urandom_range(99, 0) < 33));
    end

    // long receiver hold-off so the result register fills and s_tready drops
    always
    begin
        @(hold_kick);
        @(negedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_on <= 1'b0;
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin : result_monitor
        pattern_result_t got;
        pattern_result_t want;
        if (!rst_n)
            in_accepted <= 1'b0;
        else
        begin
            in_accepted <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[10:0];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no pending transaction: %h", $time, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: mismatch det/done/start/phase/status/steps ",
                                      "exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d"},
                                     $time, want.detected, want.complete, want.started,
                                     want.phase, want.status, want.steps,
                                     got.detected, got.complete, got.started,
                                     got.phase, got.status, got.steps);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(detector_step(s_tuser, s_tdata[0]));
        end
    end

    // ---------------- stimulus ----------------
    function automatic void push_item(logic [1:0] op, logic lvl);
        pending_items.push_back('{op: op, lvl: lvl});
        queued_count++;
    endfunction

    task automatic settle();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            tipd_pkg::REG_PHASE_COUNT:     cfg_phases = val[2:0];
            tipd_pkg::REG_PHASE_DURATIONS: cfg_durs   = val;
            tipd_pkg::REG_FIXED_MASK:      cfg_fixed  = val[3:0];
            tipd_pkg::REG_STATE_COUNTS:    cfg_counts = val[15:0];
            tipd_pkg::REG_STATE_LEVELS:    cfg_levels = val[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_config(logic [2:0] cnt, logic [63:0] durs, logic [3:0] mask,
                                logic [15:0] cnts, logic [31:0] lvls);
        write_reg(tipd_pkg::REG_PHASE_COUNT, 64'(cnt));
        write_reg(tipd_pkg::REG_PHASE_DURATIONS, durs);
        write_reg(tipd_pkg::REG_FIXED_MASK, 64'(mask));
        write_reg(tipd_pkg::REG_STATE_COUNTS, 64'(cnts));
        write_reg(tipd_pkg::REG_STATE_LEVELS, 64'(lvls));
    endtask

    task automatic write_random_config();
        logic [63:0] durs;
        logic [15:0] cnts;
        for (int p = 0; p < 4; p++)
        begin
            durs[p*16 +: 16] = ($urandom_range(9, 0) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(12, 0));
            cnts[p*4 +: 4]   = ($urandom_range(9, 0) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(8, 0));
        end
        write_config(($urandom_range(4, 0) == 0) ? 3'($urandom_range(7, 0))
                                                 : 3'($urandom_range(4, 1)),
                     durs, 4'($urandom), cnts, $urandom);
        // unmapped indexes must leave the registers alone
        for (int i = tipd_pkg::REG_STATE_LEVELS + 1; i < 8; i++)
            if ($urandom_range(2, 0) == 0)
                write_reg(3'(i), {$urandom, $urandom});
    endtask

    // one pass through the configured phases, mostly matching levels
    task automatic queue_pattern_run();
        int unsigned cnt;
        int unsigned n;
        int unsigned ticks;
        logic        lvl;
        cnt = phases_used();
        for (int unsigned p = 0; p < cnt; p++)
        begin
            n = levels_of(p);
            if (n == 0)
                push_item(tipd_pkg::OP_ACTIVITY, 1'($urandom));
            for (int unsigned k = 0; k < n; k++)
            begin
                lvl = cfg_levels[p*8 + k];
                if ($urandom_range(99, 0) < 8)
                    lvl = ~lvl;
                push_item(tipd_pkg::OP_ACTIVITY, lvl);
                if ($urandom_range(99, 0) < 10)
                    push_item(tipd_pkg::OP_TICK, 1'($urandom));
            end
            if (cfg_fixed[p])
            begin
                ticks = 32'(cfg_durs[p*16 +: 16]);
                if (ticks == 0)
                    ticks = 1;
                if (ticks > 40)
                    ticks = 40;
                repeat (ticks) push_item(tipd_pkg::OP_TICK, 1'($urandom));
            end
        end
        push_item(tipd_pkg::OP_CHECK, 1'($urandom));
    endtask

    initial begin
        int target;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing configured: activity ignored, tick with no timer, idle check
        push_item(tipd_pkg::OP_ACTIVITY, 1'b0);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b1);
        push_item(tipd_pkg::OP_TICK, 1'b1);
        push_item(tipd_pkg::OP_CHECK, 1'b0);
        push_item(OP_UNUSED, 1'b1);
        settle();

        // phase count above the limit, eight levels in phase 0, count 15 in phase 2
        write_config(3'd7, 64'hFFFF_0000_0003_0005, 4'b0100, 16'h0F18, 32'h00FF_01A5);
        for (int k = 0; k < 8; k++)
            push_item(tipd_pkg::OP_ACTIVITY, cfg_levels[k]);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b0);
        push_item(tipd_pkg::OP_TICK, 1'b0);
        settle();
        // phase 1 now lies beyond the phase count and finishes as the last one
        write_reg(tipd_pkg::REG_PHASE_COUNT, 64'd1);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b1);
        push_item(tipd_pkg::OP_CHECK, 1'b1);
        push_item(tipd_pkg::OP_CHECK, 1'b0);
        settle();

        // phase with no levels, fixed zero duration
        write_config(3'd1, 64'd0, 4'b0001, 16'h0000, 32'd0);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b1);
        push_item(tipd_pkg::OP_TICK, 1'b0);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b0);
        push_item(tipd_pkg::OP_ACTIVITY, 1'b1);
        push_item(OP_UNUSED, 1'b0);
        settle();

        for (int s = 0; s < 10; s++)
        begin
            idle_mode = s % 4;
            if (s == 0)
                write_config(3'd7, '1, 4'hF, 16'hFFFF, '1);
            else if (s == 1)
                write_config(3'd1, '0, 4'h0, 16'h0000, '0);
            else
                write_random_config();
            if (s == 4)
                -> hold_kick;
            target = queued_count + 50;
            while (queued_count < target)
            begin
                if ($urandom_range(3, 0) != 0)
                    queue_pattern_run();
                else
                    repeat ($urandom_range(5, 1))
                        push_item(2'($urandom_range(3, 0)), 1'($urandom));
            end
            settle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
